[sv/pct_pkg.sv]
// ----------------------------------------------------------------------------
// pct_pkg
// Types and constants shared by the pair collision test block.
// ----------------------------------------------------------------------------
package pct_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;
  localparam int SLOT_W              = 6;
  localparam int OUT_DEPTH           = 8;
  localparam int OUT_AW              = $clog2(OUT_DEPTH);
  localparam int PEND_W              = $clog2(OUT_DEPTH + 1);

  localparam logic [1:0] KIND_CIRCLE = 2'd0;
  localparam logic [1:0] KIND_BOX    = 2'd1;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [22:0]        reach;
    logic [22:0]        radius;
    logic signed [15:0] bound_x;
    logic signed [15:0] bound_y;
    logic [14:0]        bound_w;
    logic [14:0]        bound_h;
    logic [31:0]        scale_xy;
  } body_t;

  typedef enum logic [1:0] {
    PAIR_NONE,
    PAIR_CC,
    PAIR_BB,
    PAIR_CB
  } pair_t;

  typedef struct packed {
    logic valid;
    logic write;
  } tag_t;

  typedef struct packed {
    logic near;
    logic contact;
  } result_t;

endpackage

[sv/pct_if.sv]
// ----------------------------------------------------------------------------
// pct_if
// Channels of the pair collision test block: items in, results out.
// ----------------------------------------------------------------------------
interface pct_item_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [5:0]         slot;
  logic [1:0]         kind;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic [22:0]        reach;
  logic [22:0]        radius;
  logic signed [15:0] bound_x;
  logic signed [15:0] bound_y;
  logic [14:0]        bound_w;
  logic [14:0]        bound_h;
  logic [31:0]        scale_xy;

  modport source (
    output valid, op, slot, kind, pos_x, pos_y, reach, radius,
           bound_x, bound_y, bound_w, bound_h, scale_xy,
    input  ready
  );
  modport sink (
    input  valid, op, slot, kind, pos_x, pos_y, reach, radius,
           bound_x, bound_y, bound_w, bound_h, scale_xy,
    output ready
  );
endinterface

interface pct_result_if;
  logic valid;
  logic ready;
  logic near;
  logic contact;

  modport source (output valid, near, contact, input ready);
  modport sink (input valid, near, contact, output ready);
endinterface

[sv/pct_eval.sv]
// ----------------------------------------------------------------------------
// pct_eval
// Three-stage arithmetic pipeline: differences and scaled sizes, squares,
// then the broad and narrow compares.
// ----------------------------------------------------------------------------
module pct_eval (
  input  logic             clk,
  input  logic             rst,
  input  pct_pkg::tag_t    tag,
  input  pct_pkg::body_t   stored,
  input  pct_pkg::body_t   probe,
  output logic             res_valid,
  output pct_pkg::result_t res
);

  logic               v2, w2, v3, w3;
  pct_pkg::pair_t     pair_next, pair2, pair3;

  pct_pkg::body_t     circ, box;
  logic signed [24:0] dx_next, dy_next;
  logic signed [24:0] cpx, cpy, lo_x, lo_y, hi_x, hi_y, qx, qy;
  logic signed [25:0] cbx_next, cby_next;
  logic signed [16:0] bdx, bdy;
  logic [16:0]        abdx, abdy;
  logic [30:0]        pws, pwi, phs, phi;

  logic signed [24:0] d_x, d_y;
  logic [23:0]        reach_sum, rad_sum;
  logic signed [25:0] cb_x, cb_y;
  logic [22:0]        c_rad;
  logic [16:0]        bb_x, bb_y;
  logic [22:0]        sw_s, sw_i, sh_s, sh_i;

  logic [24:0]        adx, ady;
  logic [25:0]        acbx, acby;
  logic [23:0]        sw_sum, sh_sum;

  logic [47:0]        sq_dx, sq_dy, sq_reach, sq_rad;
  logic [49:0]        sq_cbx, sq_cby;
  logic [45:0]        sq_crad;
  logic               box_ok;

  logic [48:0]        d2;
  logic [50:0]        c2;
  logic               near, hit;

  always_comb begin
    if (stored.kind == pct_pkg::KIND_CIRCLE && probe.kind == pct_pkg::KIND_CIRCLE) begin
      pair_next = pct_pkg::PAIR_CC;
    end else if (stored.kind == pct_pkg::KIND_BOX && probe.kind == pct_pkg::KIND_BOX) begin
      pair_next = pct_pkg::PAIR_BB;
    end else if ((stored.kind == pct_pkg::KIND_CIRCLE && probe.kind == pct_pkg::KIND_BOX) ||
                 (stored.kind == pct_pkg::KIND_BOX && probe.kind == pct_pkg::KIND_CIRCLE)) begin
      pair_next = pct_pkg::PAIR_CB;
    end else begin
      pair_next = pct_pkg::PAIR_NONE;
    end

    dx_next = $signed({stored.pos_x[23], stored.pos_x}) - $signed({probe.pos_x[23], probe.pos_x});
    dy_next = $signed({stored.pos_y[23], stored.pos_y}) - $signed({probe.pos_y[23], probe.pos_y});

    if (stored.kind == pct_pkg::KIND_CIRCLE) begin
      circ = stored;
      box  = probe;
    end else begin
      circ = probe;
      box  = stored;
    end

    // The box spans its bound corner plus its unscaled size, in Q16.8.
    cpx  = $signed({circ.pos_x[23], circ.pos_x});
    cpy  = $signed({circ.pos_y[23], circ.pos_y});
    lo_x = $signed({box.bound_x[15], box.bound_x, 8'd0});
    lo_y = $signed({box.bound_y[15], box.bound_y, 8'd0});
    hi_x = lo_x + $signed({2'b00, box.bound_w, 8'd0});
    hi_y = lo_y + $signed({2'b00, box.bound_h, 8'd0});
    qx   = (cpx > hi_x) ? hi_x : ((cpx < lo_x) ? lo_x : cpx);
    qy   = (cpy > hi_y) ? hi_y : ((cpy < lo_y) ? lo_y : cpy);
    cbx_next = $signed({cpx[24], cpx}) - $signed({qx[24], qx});
    cby_next = $signed({cpy[24], cpy}) - $signed({qy[24], qy});

    bdx  = $signed({stored.bound_x[15], stored.bound_x}) - $signed({probe.bound_x[15], probe.bound_x});
    bdy  = $signed({stored.bound_y[15], stored.bound_y}) - $signed({probe.bound_y[15], probe.bound_y});
    abdx = bdx[16] ? 17'(-bdx) : 17'(bdx);
    abdy = bdy[16] ? 17'(-bdy) : 17'(bdy);

    pws = {16'd0, stored.bound_w} * {15'd0, stored.scale_xy[15:0]};
    pwi = {16'd0, probe.bound_w} * {15'd0, probe.scale_xy[15:0]};
    phs = {16'd0, stored.bound_h} * {15'd0, stored.scale_xy[31:16]};
    phi = {16'd0, probe.bound_h} * {15'd0, probe.scale_xy[31:16]};
  end

  always_ff @(posedge clk) begin
    d_x       <= dx_next;
    d_y       <= dy_next;
    reach_sum <= {1'b0, stored.reach} + {1'b0, probe.reach};
    rad_sum   <= {1'b0, stored.radius} + {1'b0, probe.radius};
    cb_x      <= cbx_next;
    cb_y      <= cby_next;
    c_rad     <= circ.radius;
    bb_x      <= {abdx[15:0], 1'b0};
    bb_y      <= {abdy[15:0], 1'b0};
    sw_s      <= pws[30:8];
    sw_i      <= pwi[30:8];
    sh_s      <= phs[30:8];
    sh_i      <= phi[30:8];
    pair2     <= pair_next;
    w2        <= tag.write;
  end

  always_comb begin
    adx    = d_x[24] ? 25'(-d_x) : 25'(d_x);
    ady    = d_y[24] ? 25'(-d_y) : 25'(d_y);
    acbx   = cb_x[25] ? 26'(-cb_x) : 26'(cb_x);
    acby   = cb_y[25] ? 26'(-cb_y) : 26'(cb_y);
    sw_sum = {1'b0, sw_s} + {1'b0, sw_i};
    sh_sum = {1'b0, sh_s} + {1'b0, sh_i};
  end

  always_ff @(posedge clk) begin
    sq_dx    <= {24'd0, adx[23:0]} * {24'd0, adx[23:0]};
    sq_dy    <= {24'd0, ady[23:0]} * {24'd0, ady[23:0]};
    sq_reach <= {24'd0, reach_sum} * {24'd0, reach_sum};
    sq_rad   <= {24'd0, rad_sum} * {24'd0, rad_sum};
    sq_cbx   <= {25'd0, acbx[24:0]} * {25'd0, acbx[24:0]};
    sq_cby   <= {25'd0, acby[24:0]} * {25'd0, acby[24:0]};
    sq_crad  <= {23'd0, c_rad} * {23'd0, c_rad};
    box_ok   <= ({7'd0, bb_x} < sw_sum) && ({7'd0, bb_y} < sh_sum);
    pair3    <= pair2;
    w3       <= w2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= tag.valid;
      v3 <= v2;
    end
  end

  always_comb begin
    d2   = {1'b0, sq_dx} + {1'b0, sq_dy};
    c2   = {1'b0, sq_cbx} + {1'b0, sq_cby};
    near = d2 <= {1'b0, sq_reach};
    case (pair3)
      pct_pkg::PAIR_CC: hit = d2 <= {1'b0, sq_rad};
      pct_pkg::PAIR_BB: hit = box_ok;
      pct_pkg::PAIR_CB: hit = c2 < {5'd0, sq_crad};
      default:          hit = 1'b0;
    endcase
    res_valid   = v3;
    res.near    = near && !w3;
    res.contact = near && hit && !w3;
  end

endmodule

[sv/pair_collision_test_top.sv]
// Each result is written into the result queue before it is offered.
// Throughput: one item per cycle, sustained while results are taken.
// Up to eight items may be outstanding; item ready drops while eight are.
// Reset clears the pipeline, the result queue and the counters; the collider
// table is not cleared and holds whatever was last written to each entry.
// ----------------------------------------------------------------------------
// pair_collision_test_top
// Collider table in one memory, read per item, followed by the evaluation
// pipeline and a small result queue.
// ----------------------------------------------------------------------------
module pair_collision_test_top #(
  parameter int TABLE_DEPTH = pct_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  pct_item_if.sink     item,
  pct_result_if.source result
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int SLOTS = 2 ** pct_pkg::SLOT_W;

  logic [AW-1:0]    slot_map [SLOTS];
  logic [AW-1:0]    addr;
  pct_pkg::body_t   mem [TABLE_DEPTH];
  pct_pkg::body_t   item_body, item_q, entry;
  pct_pkg::tag_t    tag1;
  logic             accept, pop;

  logic             res_valid;
  pct_pkg::result_t res;
  pct_pkg::result_t rq [pct_pkg::OUT_DEPTH];
  logic [pct_pkg::OUT_AW-1:0] wptr, rptr;
  logic [pct_pkg::PEND_W-1:0] fcount, pending;

  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    assign slot_map[i] = AW'(i % TABLE_DEPTH);
  end

  assign addr   = slot_map[item.slot];
  assign accept = item.valid && item.ready;
  assign pop    = result.valid && result.ready;

  always_comb begin
    item_body.kind     = item.kind;
    item_body.pos_x    = item.pos_x;
    item_body.pos_y    = item.pos_y;
    item_body.reach    = item.reach;
    item_body.radius   = item.radius;
    item_body.bound_x  = item.bound_x;
    item_body.bound_y  = item.bound_y;
    item_body.bound_w  = item.bound_w;
    item_body.bound_h  = item.bound_h;
    item_body.scale_xy = item.scale_xy;
  end

  always_ff @(posedge clk) begin
    if (accept && !item.op) begin
      mem[addr] <= item_body;
    end
    entry  <= mem[addr];
    item_q <= item_body;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else begin
      tag1.valid <= accept;
      tag1.write <= !item.op;
    end
  end

  pct_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .tag       (tag1),
    .stored    (entry),
    .probe     (item_q),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (res_valid) begin
      rq[wptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= '0;
      rptr    <= '0;
      fcount  <= '0;
      pending <= '0;
    end else begin
      if (res_valid) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({res_valid, pop})
        2'b10:   fcount <= fcount + 1'b1;
        2'b01:   fcount <= fcount - 1'b1;
        default: fcount <= fcount;
      endcase
      case ({accept, pop})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  assign item.ready     = pending < pct_pkg::PEND_W'(pct_pkg::OUT_DEPTH);
  assign result.valid   = fcount != '0;
  assign result.near    = rq[rptr].near;
  assign result.contact = rq[rptr].contact;

endmodule

[sv/pct_check.sv]
// ----------------------------------------------------------------------------
// pct_check
// Port-level checks on the pair collision test block, bound to the top level.
// ----------------------------------------------------------------------------
module pct_check (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_ready,
  input logic result_valid,
  input logic result_ready,
  input logic result_near,
  input logic result_contact
);

  logic [pct_pkg::PEND_W-1:0] outstanding;
  logic                       acc, pop;

  assign acc = item_valid && item_ready;
  assign pop = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      case ({acc, pop})
        2'b10:   outstanding <= outstanding + 1'b1;
        2'b01:   outstanding <= outstanding - 1'b1;
        default: outstanding <= outstanding;
      endcase
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_near) && $stable(result_contact))
    else $error("stalled result changed or vanished");

  a_contact_near: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_near || !result_contact)
    else $error("contact reported without near");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> outstanding != '0)
    else $error("result offered with no item outstanding");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> outstanding == pct_pkg::PEND_W'(pct_pkg::OUT_DEPTH))
    else $error("item ready low while the queue has room");

endmodule

bind pair_collision_test_top pct_check u_check (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_near    (result.near),
  .result_contact (result.contact)
);

[tb/sv/pct_tb_pkg.sv]
// ----------------------------------------------------------------------------
// pct_tb_pkg
// Operation and collider kind codes shared by the testbench and its checker.
// ----------------------------------------------------------------------------
package pct_tb_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

endpackage

[tb/sv/contact_check.sv]
// ----------------------------------------------------------------------------
// contact_check
// Watches the item and result channels of the pair collision test block.
// It keeps its own collider table, works out near and contact for every
// accepted item, and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module contact_check (
  input  logic  clk,
  input  logic  rst,
  pct_item_if   item,
  pct_result_if result,
  output int    mismatches,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import pct_pkg::*;
  import pct_tb_pkg::*;

  body_t   collider_tab [TABLE_DEPTH_DEFAULT];
  result_t outcome_q [$];
  int      bad = 0;

  assign mismatches = bad;

  function automatic longint sqr(longint d);
    return d * d;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    longint r;
    r = (v > hi) ? hi : v;
    return (r < lo) ? lo : r;
  endfunction

  function automatic longint scaled_size(logic [14:0] size, logic [15:0] s);
    return (longint'(size) * longint'(s)) >>> 8;
  endfunction

  function automatic bit box_overlap(body_t a, body_t b);
    longint sw, sh, dx, dy;
    sw = scaled_size(a.bound_w, a.scale_xy[15:0]) + scaled_size(b.bound_w, b.scale_xy[15:0]);
    sh = scaled_size(a.bound_h, a.scale_xy[31:16]) + scaled_size(b.bound_h, b.scale_xy[31:16]);
    dx = longint'($signed(a.bound_x)) - longint'($signed(b.bound_x));
    dy = longint'($signed(a.bound_y)) - longint'($signed(b.bound_y));
    if (dx < 0) begin
      dx = -dx;
    end
    if (dy < 0) begin
      dy = -dy;
    end
    return (2 * dx < sw) && (2 * dy < sh);
  endfunction

  function automatic bit circle_in_box(body_t c, body_t box);
    longint px, py, x0, y0, qx, qy;
    px = longint'($signed(c.pos_x));
    py = longint'($signed(c.pos_y));
    x0 = longint'($signed(box.bound_x)) * 256;
    y0 = longint'($signed(box.bound_y)) * 256;
    qx = clip(px, x0, x0 + longint'(box.bound_w) * 256);
    qy = clip(py, y0, y0 + longint'(box.bound_h) * 256);
    return sqr(px - qx) + sqr(py - qy) < sqr(longint'(c.radius));
  endfunction

  function automatic result_t pair_outcome(body_t s, body_t b);
    result_t r;
    longint  dist2;
    r = '0;
    dist2 = sqr(longint'($signed(s.pos_x)) - longint'($signed(b.pos_x)))
          + sqr(longint'($signed(s.pos_y)) - longint'($signed(b.pos_y)));
    r.near = dist2 <= sqr(longint'(s.reach) + longint'(b.reach));
    if (r.near) begin
      if (s.kind == KIND_CIRCLE && b.kind == KIND_CIRCLE) begin
        r.contact = dist2 <= sqr(longint'(s.radius) + longint'(b.radius));
      end else if (s.kind == KIND_BOX && b.kind == KIND_BOX) begin
        r.contact = box_overlap(s, b);
      end else if (s.kind == KIND_CIRCLE && b.kind == KIND_BOX) begin
        r.contact = circle_in_box(s, b);
      end else if (s.kind == KIND_BOX && b.kind == KIND_CIRCLE) begin
        r.contact = circle_in_box(b, s);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    body_t   probe;
    result_t want;
    result_t got;
    if (!rst) begin
      if (item.valid && item.ready) begin
        probe.kind     = item.kind;
        probe.pos_x    = item.pos_x;
        probe.pos_y    = item.pos_y;
        probe.reach    = item.reach;
        probe.radius   = item.radius;
        probe.bound_x  = item.bound_x;
        probe.bound_y  = item.bound_y;
        probe.bound_w  = item.bound_w;
        probe.bound_h  = item.bound_h;
        probe.scale_xy = item.scale_xy;
        if (item.op == OP_WRITE) begin
          collider_tab[item.slot] = probe;
          outcome_q.insert(outcome_q.size(), '0);
        end else begin
          outcome_q.insert(outcome_q.size(), pair_outcome(collider_tab[item.slot], probe));
        end
      end
      if (result.valid && result.ready) begin
        got.near    = result.near;
        got.contact = result.contact;
        if (outcome_q.size() == 0) begin
          bad++;
          if (bad <= 10) begin
            $display("%0t: result near/contact %0b/%0b arrived with none due",
                     $realtime, got.near, got.contact);
          end
        end else begin
          want = outcome_q.pop_front();
          if (want.near !== got.near || want.contact !== got.contact) begin
            bad++;
            if (bad <= 10) begin
              $display("%0t: near/contact expected %0b/%0b, got %0b/%0b",
                       $realtime, want.near, want.contact, got.near, got.contact);
            end
          end
        end
      end
    end
    pending <= outcome_q.size();
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the pair collision test block. A directed set covers touching
// and strict boundaries, truncated box widths, other kinds and field extremes;
// random writes and tests follow, with idle bursts on both channels, one long
// result stall and two full drains. The checker beside the block gives the
// verdict its mismatch count.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pct_pkg::*;
  import pct_tb_pkg::*;

  localparam int N_RANDOM     = 1130;
  localparam int CALM_ITEMS   = 150;
  localparam int HOLD_CYCLES  = 100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int P_MAX        = 8388607;
  localparam int P_MIN        = -8388608;
  localparam int B_MAX        = 32767;
  localparam int B_MIN        = -32768;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   pending;
  int   cycles;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;

  bit    written [TABLE_DEPTH_DEFAULT];
  body_t shadow [TABLE_DEPTH_DEFAULT];
  int    written_slots [$];

  pct_item_if   item_ch ();
  pct_result_if result_ch ();

  pair_collision_test_top uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  contact_check u_check (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  function automatic body_t collider(logic [1:0] kind, int px, int py, int reach,
                                     int radius, int bx, int by, int bw, int bh,
                                     logic [31:0] scale);
    body_t b;
    b.kind     = kind;
    b.pos_x    = 24'(px);
    b.pos_y    = 24'(py);
    b.reach    = 23'(reach);
    b.radius   = 23'(radius);
    b.bound_x  = 16'(bx);
    b.bound_y  = 16'(by);
    b.bound_w  = 15'(bw);
    b.bound_h  = 15'(bh);
    b.scale_xy = scale;
    return b;
  endfunction

  function automatic body_t rand_body();
    body_t        b;
    logic [191:0] raw;
    int           k;
    int           px;
    int           py;
    if ($urandom_range(0, 9) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      b = raw[$bits(body_t)-1:0];
    end else begin
      k = $urandom_range(0, 9);
      px = int'($urandom_range(0, 32768)) - 16384;
      py = int'($urandom_range(0, 32768)) - 16384;
      b = collider(k < 4 ? KIND_CIRCLE : k < 8 ? KIND_BOX : k == 8 ? KIND_OTHER : KIND_SPARE,
                   px, py, $urandom_range(0, 40 * 256), $urandom_range(0, 24 * 256),
                   (px >>> 8) + int'($urandom_range(0, 16)) - 8,
                   (py >>> 8) + int'($urandom_range(0, 16)) - 8,
                   $urandom_range(0, 48), $urandom_range(0, 48),
                   {16'($urandom_range(0, 640)), 16'($urandom_range(0, 640))});
    end
    return b;
  endfunction

  function automatic body_t nudge(body_t s);
    body_t b;
    b = rand_body();
    b.pos_x   = 24'(s.pos_x + (int'($urandom_range(0, 2048)) - 1024));
    b.pos_y   = 24'(s.pos_y + (int'($urandom_range(0, 2048)) - 1024));
    b.bound_x = 16'(s.bound_x + (int'($urandom_range(0, 16)) - 8));
    b.bound_y = 16'(s.bound_y + (int'($urandom_range(0, 16)) - 8));
    return b;
  endfunction

  task automatic push_item(input logic op, input logic [5:0] slot, input body_t b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item_ch.valid    <= 1'b1;
    item_ch.op       <= op;
    item_ch.slot     <= slot;
    item_ch.kind     <= b.kind;
    item_ch.pos_x    <= b.pos_x;
    item_ch.pos_y    <= b.pos_y;
    item_ch.reach    <= b.reach;
    item_ch.radius   <= b.radius;
    item_ch.bound_x  <= b.bound_x;
    item_ch.bound_y  <= b.bound_y;
    item_ch.bound_w  <= b.bound_w;
    item_ch.bound_h  <= b.bound_h;
    item_ch.scale_xy <= b.scale_xy;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (op == OP_WRITE) begin
      if (!written[slot]) begin
        written_slots.insert(written_slots.size(), int'(slot));
      end
      written[slot] = 1'b1;
      shadow[slot] = b;
    end
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    result_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm) begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("pair_collision_test_top: mismatch");
    $finish;
  end

  initial begin
    body_t b;
    int    slot;
    item_ch.valid    = 1'b0;
    item_ch.op       = OP_WRITE;
    item_ch.slot     = '0;
    item_ch.kind     = KIND_CIRCLE;
    item_ch.pos_x    = '0;
    item_ch.pos_y    = '0;
    item_ch.reach    = '0;
    item_ch.radius   = '0;
    item_ch.bound_x  = '0;
    item_ch.bound_y  = '0;
    item_ch.bound_w  = '0;
    item_ch.bound_h  = '0;
    item_ch.scale_xy = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    push_item(OP_WRITE, 0, collider(KIND_CIRCLE, 0, 0, 2560, 512, 0, 0, 0, 0, 0));
    push_item(OP_TEST, 0, collider(KIND_CIRCLE, 768, 1024, 768, 768, 0, 0, 0, 0, 0));
    push_item(OP_TEST, 0, collider(KIND_CIRCLE, 768, 1025, 768, 768, 0, 0, 0, 0, 0));
    push_item(OP_TEST, 0, collider(KIND_CIRCLE, 3328, 0, 768, 2816, 0, 0, 0, 0, 0));
    push_item(OP_TEST, 0, collider(KIND_CIRCLE, 3329, 0, 768, 2816, 0, 0, 0, 0, 0));
    push_item(OP_WRITE, 63,
              collider(KIND_BOX, 2560, 5120, 25600, 0, 10, 20, 8, 6, 32'h0100_0100));
    push_item(OP_TEST, 63,
              collider(KIND_BOX, 3584, 5120, 256, 0, 14, 20, 0, 6, 32'h0100_0100));
    push_item(OP_TEST, 63,
              collider(KIND_BOX, 3584, 5120, 256, 0, 14, 20, 1, 6, 32'h0100_0100));
    push_item(OP_TEST, 63,
              collider(KIND_BOX, 3584, 5120, 256, 0, 14, 20, 1, 6, 32'h00FF_00FF));
    push_item(OP_TEST, 63, collider(KIND_CIRCLE, 1280, 5120, 256, 1280, 0, 0, 0, 0, 0));
    push_item(OP_TEST, 63, collider(KIND_CIRCLE, 1280, 5120, 256, 1281, 0, 0, 0, 0, 0));
    push_item(OP_TEST, 63, collider(KIND_CIRCLE, 3072, 5632, 256, 0, 0, 0, 0, 0, 0));
    push_item(OP_TEST, 0, collider(KIND_BOX, 0, 0, 256, 0, -1, -1, 2, 2, 0));
    push_item(OP_TEST, 0, collider(KIND_OTHER, 0, 0, 0, 512, 0, 0, 0, 0, 0));
    push_item(OP_TEST, 0, collider(KIND_SPARE, 0, 0, 0, 512, 0, 0, 0, 0, 0));
    push_item(OP_WRITE, 5, collider(KIND_SPARE, P_MIN, P_MIN, P_MAX, P_MAX,
                                    B_MIN, B_MIN, B_MAX, B_MAX, 32'hFFFF_FFFF));
    push_item(OP_TEST, 5, collider(KIND_CIRCLE, P_MAX, P_MAX, P_MAX, P_MAX, 0, 0, 0, 0, 0));
    push_item(OP_TEST, 5, collider(KIND_CIRCLE, P_MIN, P_MIN, 0, 0, 0, 0, 0, 0, 0));
    push_item(OP_WRITE, 6, collider(KIND_CIRCLE, P_MAX, P_MAX, P_MAX, P_MAX,
                                    B_MAX, B_MAX, B_MAX, B_MAX, 32'hFFFF_FFFF));
    push_item(OP_TEST, 6, collider(KIND_BOX, P_MAX - 256, P_MAX, 0, 0,
                                   B_MAX, B_MAX, B_MAX, B_MAX, 32'hFFFF_FFFF));
    push_item(OP_WRITE, 7, collider(KIND_BOX, P_MIN, P_MIN, P_MAX, 0,
                                    B_MIN, B_MIN, B_MAX, B_MAX, 32'hFFFF_FFFF));
    push_item(OP_TEST, 7, collider(KIND_BOX, P_MIN, P_MIN, 0, 0,
                                   B_MAX, B_MAX, B_MAX, B_MAX, 32'hFFFF_FFFF));
    push_item(OP_TEST, 7, collider(KIND_BOX, P_MIN, P_MIN, 0, 0,
                                   B_MAX, B_MAX, B_MAX, B_MAX, 0));

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) begin
        hold_req = 1'b1;
      end
      if (i == 700) begin
        drain();
      end
      if (i == N_RANDOM - CALM_ITEMS) begin
        calm = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) begin
        push_item(OP_WRITE, 6'($urandom_range(0, TABLE_DEPTH_DEFAULT - 1)), rand_body());
      end else begin
        slot = written_slots[$urandom_range(0, written_slots.size() - 1)];
        b = ($urandom_range(0, 1) == 0) ? nudge(shadow[slot]) : rand_body();
        push_item(OP_TEST, 6'(slot), b);
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("pair_collision_test_top: match");
    end else begin
      $display("pair_collision_test_top: mismatch");
    end
    $finish;
  end

endmodule
